// ===== sv/tmp3_pkg.sv =====
// Shared types and constants of the chained 3x3 matrix product.
// No dependencies; compiled before every other file of the block.
package tmp3_pkg;

  localparam int unsigned ElemW = 32;
  localparam int unsigned PosW  = 4;
  localparam int unsigned AccW  = 64;

  typedef enum logic [2:0] {
    StLoad,
    StPass1,
    StDrain1,
    StPass2,
    StDrain2,
    StEmitRd,
    StEmit
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // write input element to operand store
    logic issue;       // start one multiply-accumulate
    logic phase2;      // issue belongs to the second product
    logic first;       // first term of a dot product
    logic last;        // last term of a dot product
    logic out_read;    // read a result element for output
    logic clear_clamp; // new run: clear sticky saturation flag
  } cmd_t;

endpackage

// ===== sv/tmp3_in_if.sv =====
// Input channel of the matrix product block: valid/ready plus one element.
// Depends on tmp3_pkg.
interface tmp3_in_if;
  import tmp3_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ElemW-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

// ===== sv/tmp3_out_if.sv =====
// Output channel of the matrix product block: valid/ready plus one result element.
// Depends on tmp3_pkg.
interface tmp3_out_if;
  import tmp3_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ElemW-1:0] product_value;
  logic [PosW-1:0]         element_position;
  logic                    clamped;
  logic                    last_element;

  modport source (output valid, output product_value, output element_position,
                  output clamped, output last_element, input ready);
  modport sink   (input valid, input product_value, input element_position,
                  input clamped, input last_element, output ready);
endinterface

// ===== sv/tmp3_datapath.sv =====
// Datapath: operand and intermediate stores, shared multiplier, saturating
// accumulator and scaling. Depends on tmp3_pkg.
module tmp3_datapath #(
  parameter int DIM       = 3,
  parameter int FRAC_BITS = 16,
  localparam int MatSize  = DIM * DIM,
  localparam int LoadTot  = 3 * MatSize,
  localparam int AW       = $clog2(LoadTot),
  localparam int MW       = $clog2(MatSize)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tmp3_pkg::cmd_t                    cmd_i,
  input  logic [AW-1:0]                     ld_addr_i,
  input  logic [AW-1:0]                     a_addr_i,
  input  logic [AW-1:0]                     b_addr_i,
  input  logic [MW-1:0]                     t_addr_i,
  input  logic [MW-1:0]                     dst_addr_i,
  input  logic signed [tmp3_pkg::ElemW-1:0] in_data_i,
  output logic signed [tmp3_pkg::ElemW-1:0] out_data_o,
  output logic                              clamped_o,
  output logic                              busy_o
);
  import tmp3_pkg::*;

  localparam logic signed [AccW-1:0]  AccMax  = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0]  AccMin  = {1'b1, {(AccW-1){1'b0}}};
  localparam logic signed [ElemW-1:0] ElemMax = {1'b0, {(ElemW-1){1'b1}}};
  localparam logic signed [ElemW-1:0] ElemMin = {1'b1, {(ElemW-1){1'b0}}};

  logic signed [ElemW-1:0] opnd_mem [LoadTot];
  logic signed [ElemW-1:0] inter_mem [MatSize];

  logic signed [ElemW-1:0] rdata_a_q, rdata_b_q, rdata_t_q;
  logic                    rd_en;

  // stage 1: read data, stage 2: product, stage 3: accumulator
  logic          v1_q, v2_q, v3_q;
  logic          ph1_q, ph2_q, ph3_q;
  logic          first1_q, first2_q;
  logic          last1_q, last2_q;
  logic [MW-1:0] dst1_q, dst2_q, dst3_q;

  logic signed [AccW-1:0] prod_q, acc_q, acc_d;
  logic signed [ElemW-1:0] mul_x;
  logic signed [AccW:0]    sum_wide;
  logic                    acc_ovf;
  logic signed [AccW-1:0]  scaled;
  logic                    scale_ovf;
  logic signed [ElemW-1:0] res_val;
  logic                    res_we;
  logic                    clamp_q;

  logic                    opnd_we;
  logic [AW-1:0]           opnd_waddr;
  logic signed [ElemW-1:0] opnd_wdata;

  assign rd_en = cmd_i.issue | cmd_i.out_read;

  // Result of the first product goes to the intermediate store, the final
  // product overwrites the dead A region of the operand store.
  assign res_we     = v3_q;
  assign opnd_we    = cmd_i.load | (res_we & ph3_q);
  assign opnd_waddr = cmd_i.load ? ld_addr_i : AW'(dst3_q);
  assign opnd_wdata = cmd_i.load ? in_data_i : res_val;

  always_ff @(posedge clk_i) begin
    if (opnd_we) begin
      opnd_mem[opnd_waddr] <= opnd_wdata;
    end
    if (res_we && !ph3_q) begin
      inter_mem[dst3_q] <= res_val;
    end
    if (rd_en) begin
      rdata_a_q <= opnd_mem[a_addr_i];
      rdata_b_q <= opnd_mem[b_addr_i];
      rdata_t_q <= inter_mem[t_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      clamp_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q & last2_q;
      if (cmd_i.clear_clamp) begin
        clamp_q <= 1'b0;
      end else if (acc_ovf || (v3_q && scale_ovf)) begin
        clamp_q <= 1'b1;
      end
    end
  end

  assign mul_x = ph1_q ? rdata_t_q : rdata_a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      ph1_q    <= cmd_i.phase2;
      first1_q <= cmd_i.first;
      last1_q  <= cmd_i.last;
      dst1_q   <= dst_addr_i;
    end
    if (v1_q) begin
      prod_q   <= AccW'(mul_x) * AccW'(rdata_b_q);
      ph2_q    <= ph1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      dst2_q   <= dst1_q;
    end
    if (v2_q) begin
      acc_q  <= acc_d;
      ph3_q  <= ph2_q;
      dst3_q <= dst2_q;
    end
  end

  // Saturating accumulate: overflow when the two top bits of the sum differ
  always_comb begin
    sum_wide = {acc_q[AccW-1], acc_q} + {prod_q[AccW-1], prod_q};
    acc_ovf  = 1'b0;
    if (first2_q) begin
      acc_d = prod_q;
    end else if (sum_wide[AccW] != sum_wide[AccW-1]) begin
      acc_d   = sum_wide[AccW] ? AccMin : AccMax;
      acc_ovf = v2_q;
    end else begin
      acc_d = sum_wide[AccW-1:0];
    end
  end

  // Arithmetic shift rounds towards minus infinity, then clamp to 32 bits
  always_comb begin
    scaled    = acc_q >>> FRAC_BITS;
    scale_ovf = !((&scaled[AccW-1:ElemW-1]) || !(|scaled[AccW-1:ElemW-1]));
    if (scale_ovf) begin
      res_val = scaled[AccW-1] ? ElemMin : ElemMax;
    end else begin
      res_val = scaled[ElemW-1:0];
    end
  end

  assign out_data_o = rdata_a_q;
  assign clamped_o  = clamp_q;
  assign busy_o     = v1_q | v2_q | v3_q;

  a_no_load_during_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && (v1_q || v2_q || v3_q)))
    else $error("input load while the pipeline holds work");

  a_writeback_from_last_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> $past(v2_q) && $past(last2_q))
    else $error("result written without a completed dot product");

  a_read_not_during_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && rd_en))
    else $error("store read while loading");
endmodule

// ===== sv/tmp3_ctrl.sv =====
// Controller: sequences loading, the two matrix products and result output.
// Depends on tmp3_pkg; drives tmp3_datapath through cmd_t and address lines.
module tmp3_ctrl #(
  parameter int DIM      = 3,
  localparam int MatSize = DIM * DIM,
  localparam int LoadTot = 3 * MatSize,
  localparam int AW      = $clog2(LoadTot),
  localparam int MW      = $clog2(MatSize),
  localparam int IW      = $clog2(DIM)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tmp3_pkg::PosW-1:0]     out_pos_o,
  output logic                          out_last_o,
  input  logic                          busy_i,
  output tmp3_pkg::cmd_t                cmd_o,
  output logic [AW-1:0]                 ld_addr_o,
  output logic [AW-1:0]                 a_addr_o,
  output logic [AW-1:0]                 b_addr_o,
  output logic [MW-1:0]                 t_addr_o,
  output logic [MW-1:0]                 dst_addr_o
);
  import tmp3_pkg::*;

  state_e        state_q, state_d;
  logic [AW-1:0] ld_cnt_q, ld_cnt_d;
  logic [IW-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [MW-1:0] i_q, i_d;
  logic          in_xfer, out_xfer;
  logic          k_end, c_end, r_end, i_end;
  logic [31:0]   pos_wide;

  assign k_end = (k_q == IW'(DIM - 1));
  assign c_end = (c_q == IW'(DIM - 1));
  assign r_end = (r_q == IW'(DIM - 1));
  assign i_end = (i_q == MW'(MatSize - 1));

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      ld_cnt_q <= '0;
      r_q      <= '0;
      c_q      <= '0;
      k_q      <= '0;
      i_q      <= '0;
    end else begin
      state_q  <= state_d;
      ld_cnt_q <= ld_cnt_d;
      r_q      <= r_d;
      c_q      <= c_d;
      k_q      <= k_d;
      i_q      <= i_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ld_cnt_d    = ld_cnt_q;
    r_d         = r_q;
    c_d         = c_q;
    k_d         = k_q;
    i_d         = i_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ld_addr_o   = ld_cnt_q;
    a_addr_o    = AW'(r_q) * AW'(DIM) + AW'(k_q);
    b_addr_o    = AW'(MatSize) + AW'(k_q) * AW'(DIM) + AW'(c_q);
    t_addr_o    = MW'(r_q) * MW'(DIM) + MW'(k_q);
    dst_addr_o  = MW'(r_q) * MW'(DIM) + MW'(c_q);

    unique case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          if (ld_cnt_q == AW'(LoadTot - 1)) begin
            ld_cnt_d          = '0;
            cmd_o.clear_clamp = 1'b1;
            state_d           = StPass1;
          end else begin
            ld_cnt_d = ld_cnt_q + 1'b1;
          end
        end
      end
      StPass1, StPass2: begin
        cmd_o.issue  = 1'b1;
        cmd_o.phase2 = (state_q == StPass2);
        cmd_o.first  = (k_q == '0);
        cmd_o.last   = k_end;
        if (state_q == StPass2) begin
          b_addr_o = AW'(2 * MatSize) + AW'(k_q) * AW'(DIM) + AW'(c_q);
        end
        // k runs fastest, then column, then row; all wrap to zero at the end
        k_d = k_end ? '0 : k_q + 1'b1;
        if (k_end) begin
          c_d = c_end ? '0 : c_q + 1'b1;
          if (c_end) begin
            r_d = r_end ? '0 : r_q + 1'b1;
            if (r_end) begin
              state_d = (state_q == StPass1) ? StDrain1 : StDrain2;
            end
          end
        end
      end
      StDrain1: begin
        if (!busy_i) begin
          state_d = StPass2;
        end
      end
      StDrain2: begin
        if (!busy_i) begin
          state_d = StEmitRd;
        end
      end
      StEmitRd: begin
        cmd_o.out_read = 1'b1;
        a_addr_o       = AW'(i_q);
        state_d        = StEmit;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_xfer) begin
          if (i_end) begin
            i_d     = '0;
            state_d = StLoad;
          end else begin
            // prefetch the next element into the output register
            i_d            = i_q + 1'b1;
            cmd_o.out_read = 1'b1;
            a_addr_o       = AW'(i_q) + 1'b1;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  assign pos_wide   = 32'(i_q);
  assign out_pos_o  = pos_wide[PosW-1:0];
  assign out_last_o = i_end;

  a_one_side_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  a_emit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmitRd) |-> !busy_i)
    else $error("output started before the datapath drained");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_last_o) |=> in_ready_o && (ld_cnt_q == '0))
    else $error("block not reloading after the final result");

  a_issue_only_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> !busy_i || $past(cmd_o.issue))
    else $error("multiply issued into a draining pipeline");
endmodule

// ===== sv/triple_matrix_product_3x3_core.sv =====
// Top level of the chained matrix product A*B*C in fixed point.
// Depends on tmp3_pkg, tmp3_in_if, tmp3_out_if, tmp3_ctrl and tmp3_datapath.
//
// Usage:
//   in_i  : element stream, 3*DIM*DIM elements per run, A then B then C,
//           each row-major, FRAC_BITS fractional bits.
//   out_o : DIM*DIM result elements of A*B*C, row-major, with position,
//           sticky clamp flag of the run and a marker on the last one.
// Sequence (N = DIM):
//   Loading takes one element per cycle while the source offers one.
//   After the final input transfer the block runs two products of N^3
//   multiply-accumulates each, one per cycle through a single shared 32x32
//   multiplier, with a pipeline drain after each product and a fetch of the
//   first result. Results then leave at one per cycle while the sink takes
//   them. Input is refused from the final input transfer until the last
//   result has been taken.
// Reset: asynchronous, active low; clears the load count and clamp flag.
// Stall: a result waits in the output register until the sink takes it.
module triple_matrix_product_3x3_core #(
  parameter int DIM       = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmp3_in_if.sink    in_i,
  tmp3_out_if.source out_o
);
  import tmp3_pkg::*;

  localparam int MatSize = DIM * DIM;
  localparam int LoadTot = 3 * MatSize;
  localparam int AW      = $clog2(LoadTot);
  localparam int MW      = $clog2(MatSize);

  cmd_t          cmd;
  logic          busy;
  logic [AW-1:0] ld_addr, a_addr, b_addr;
  logic [MW-1:0] t_addr, dst_addr;

  tmp3_ctrl #(
    .DIM (DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_pos_o   (out_o.element_position),
    .out_last_o  (out_o.last_element),
    .busy_i      (busy),
    .cmd_o       (cmd),
    .ld_addr_o   (ld_addr),
    .a_addr_o    (a_addr),
    .b_addr_o    (b_addr),
    .t_addr_o    (t_addr),
    .dst_addr_o  (dst_addr)
  );

  tmp3_datapath #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .ld_addr_i  (ld_addr),
    .a_addr_i   (a_addr),
    .b_addr_i   (b_addr),
    .t_addr_i   (t_addr),
    .dst_addr_i (dst_addr),
    .in_data_i  (in_i.element_value),
    .out_data_o (out_o.product_value),
    .clamped_o  (out_o.clamped),
    .busy_o     (busy)
  );
endmodule
